@@ src/nnk_pkg.sv @@
// Package for the nearest-neighbor top-k selection block.
// Holds field widths, command codes, sequencer states and defaults.
// No dependencies; every other file of the block imports it.
package nnk_pkg;

  localparam int ID_W = 31;
  localparam int DIST_W = 32;
  localparam int CFG_W = 5;
  localparam int DEFAULT_MAX_NEIGHBORS = 16;
  localparam int NEIGHBOR_COUNT_RESET = 16;

  // Command codes carried by one input transaction.
  typedef enum logic [1:0] {
    CMD_PRELOAD = 2'd0,
    CMD_OFFER   = 2'd1,
    CMD_EMIT    = 2'd2
  } cmd_t;

  // Sequencer states of the list controller.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_READ,
    ST_INS_CMP,
    ST_CAND_CMP,
    ST_EMIT
  } state_t;

endpackage

@@ src/nearest_neighbor_top_k_select.sv @@
// Nearest-neighbor top-k selection. A start transaction is taken when busy
// is low. The user must write the neighbor count only while busy is low;
// the block does not enforce it. Preload and offer insert into a
// distance-sorted list held in a memory with one write port and one
// registered read port, shifting each farther entry up one slot with a
// read state and then a compare-and-write state. An offer into a full list
// first tests the farthest entry in a compare state, and an offer that
// loses that compare returns to idle after it. A preload into a full list,
// an emit of an empty list and the unused command leave busy low. An emit
// of n entries reads one entry per cycle and puts out n results on
// consecutive cycles, each in the cycle after its read and marked by
// result_valid for exactly one cycle; the receiver cannot stall them.
module nearest_neighbor_top_k_select
  import nnk_pkg::*;
#(
  parameter int MAX_NEIGHBORS = DEFAULT_MAX_NEIGHBORS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [ID_W-1:0]   entry_id,
  input  logic [DIST_W-1:0] entry_distance,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              result_valid,
  output logic [ID_W-1:0]   neighbor_id,
  output logic [DIST_W-1:0] neighbor_distance,
  output logic              last_of_run
);

  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CAP_RESET = (NEIGHBOR_COUNT_RESET > MAX_NEIGHBORS) ?
                             MAX_NEIGHBORS : NEIGHBOR_COUNT_RESET;

  logic [CW-1:0]     cap, cfg_cap;
  logic [CW-1:0]     filled_count;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ID_W-1:0]   mem_wid;
  logic [DIST_W-1:0] mem_wdist;

  // Clamp the written neighbor count to 1..MAX_NEIGHBORS.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CW'(1);
    end else if (int'(cfg_data) > MAX_NEIGHBORS) begin
      cfg_cap = CW'(MAX_NEIGHBORS);
    end else begin
      cfg_cap = CW'(int'(cfg_data));
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CW'(CAP_RESET);
    end else if (cfg_we) begin
      cap <= cfg_cap;
    end
  end

  nnk_ctrl #(
    .CW(CW),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .entry_id(entry_id),
    .entry_distance(entry_distance),
    .cap(cap),
    .cfg_we(cfg_we),
    .cfg_cap(cfg_cap),
    .busy(busy),
    .filled_count(filled_count),
    .result_valid(result_valid),
    .result_last(last_of_run),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wid(mem_wid),
    .mem_wdist(mem_wdist),
    .mem_raddr(mem_raddr),
    .mem_rid(neighbor_id),
    .mem_rdist(neighbor_distance)
  );

  nnk_mem #(
    .DEPTH(MAX_NEIGHBORS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wid(mem_wid),
    .wdist(mem_wdist),
    .raddr(mem_raddr),
    .rid(neighbor_id),
    .rdist(neighbor_distance)
  );

`ifndef ASSERT_OFF
  // The list never holds more entries than the current capacity.
  a_fill_within_cap: assert property (@(posedge clk) disable iff (rst)
    filled_count <= cap)
    else $error("fill count exceeds capacity");

  // Results only follow an emit in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without an emit in progress");

  // The final result of a run leaves the list empty.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_run) |-> (filled_count == '0))
    else $error("list not cleared after the final result");

  // An accepted emit of a non-empty list keeps the block busy next cycle.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_EMIT) && (filled_count != '0)) |=> busy)
    else $error("emit accepted but block not busy");
`endif

endmodule

@@ src/nnk_mem.sv @@
// Entry memory of the nearest-neighbor list: one id and one distance per slot.
// One write port and one read port with registered read data.
// Depends on nnk_pkg for the field widths.
module nnk_mem
  import nnk_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_NEIGHBORS,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [ID_W-1:0]   wid,
  input  logic [DIST_W-1:0] wdist,
  input  logic [AW-1:0]     raddr,
  output logic [ID_W-1:0]   rid,
  output logic [DIST_W-1:0] rdist
);

  logic [ID_W-1:0]   ids   [DEPTH];
  logic [DIST_W-1:0] dists [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      ids[waddr]   <= wid;
      dists[waddr] <= wdist;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rid   <= ids[raddr];
    rdist <= dists[raddr];
  end

endmodule

@@ src/nnk_ctrl.sv @@
// Sequencer of the nearest-neighbor list: insertion by shifting, candidate
// test against the farthest entry, and the emit sweep. Uses one distance comparator.
// Depends on nnk_pkg; drives the nnk_mem ports.
module nnk_ctrl
  import nnk_pkg::*;
#(
  parameter int CW = 5,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  logic [ID_W-1:0]   entry_id,
  input  logic [DIST_W-1:0] entry_distance,
  input  logic [CW-1:0]     cap,
  input  logic              cfg_we,
  input  logic [CW-1:0]     cfg_cap,
  output logic              busy,
  output logic [CW-1:0]     filled_count,
  output logic              result_valid,
  output logic              result_last,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [ID_W-1:0]   mem_wid,
  output logic [DIST_W-1:0] mem_wdist,
  output logic [AW-1:0]     mem_raddr,
  input  logic [ID_W-1:0]   mem_rid,
  input  logic [DIST_W-1:0] mem_rdist
);

  state_t            state, state_next;
  logic [CW-1:0]     filled, filled_next;
  logic [CW-1:0]     pos, pos_next;
  logic [ID_W-1:0]   cur_id;
  logic [DIST_W-1:0] cur_dist;
  logic              res_valid_next, res_last_next;
  logic              accept;
  logic              rd_greater;
  logic [CW-1:0]     last_idx;

  assign accept       = start && (state == ST_IDLE);
  assign busy         = (state != ST_IDLE);
  assign filled_count = filled;
  assign last_idx     = filled - CW'(1);

  // The one shared comparator: stored distance against the held distance.
  assign rd_greater = (mem_rdist > cur_dist);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      filled       <= '0;
      pos          <= '0;
      result_valid <= 1'b0;
      result_last  <= 1'b0;
    end else begin
      state        <= state_next;
      pos          <= pos_next;
      result_valid <= res_valid_next;
      result_last  <= res_last_next;
      if (cfg_we && (filled > cfg_cap)) begin
        filled <= cfg_cap;
      end else begin
        filled <= filled_next;
      end
    end
  end

  // Payload of the transaction being worked on.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id   <= entry_id;
      cur_dist <= entry_distance;
    end
  end

  // Next state, memory control and result strobe.
  always_comb begin
    state_next     = state;
    filled_next    = filled;
    pos_next       = pos;
    res_valid_next = 1'b0;
    res_last_next  = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pos[AW-1:0];
    mem_wid        = cur_id;
    mem_wdist      = cur_dist;
    mem_raddr      = last_idx[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (command)
            CMD_PRELOAD: begin
              if (filled < cap) begin
                pos_next   = filled;
                state_next = ST_INS_READ;
              end
            end
            CMD_OFFER: begin
              if (filled < cap) begin
                pos_next   = filled;
                state_next = ST_INS_READ;
              end else begin
                // Farthest entry is read now and tested next cycle.
                state_next = ST_CAND_CMP;
              end
            end
            CMD_EMIT: begin
              if (filled != '0) begin
                pos_next   = '0;
                state_next = ST_EMIT;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CAND_CMP: begin
        // Replace the farthest entry only if strictly closer.
        if (rd_greater) begin
          filled_next = last_idx;
          pos_next    = last_idx;
          state_next  = ST_INS_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_INS_READ: begin
        if (pos == '0) begin
          mem_we      = 1'b1;
          filled_next = filled + CW'(1);
          state_next  = ST_IDLE;
        end else begin
          mem_raddr  = pos[AW-1:0] - AW'(1);
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // A farther neighbor below moves up one slot; otherwise place here.
        mem_we = 1'b1;
        if (rd_greater) begin
          mem_wid    = mem_rid;
          mem_wdist  = mem_rdist;
          pos_next   = pos - CW'(1);
          state_next = ST_INS_READ;
        end else begin
          filled_next = filled + CW'(1);
          state_next  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // One read per cycle; the data shows on the result ports next cycle.
        mem_raddr      = pos[AW-1:0];
        res_valid_next = 1'b1;
        if (pos == last_idx) begin
          res_last_next = 1'b1;
          filled_next   = '0;
          state_next    = ST_IDLE;
        end else begin
          pos_next = pos + CW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
